// ===== sv/stpf_pkg.sv =====
// Shared types, codes and constants of the serial tagged packet queue.
package stpf_pkg;

   // Default number of descriptors the queue can hold.
   localparam int QUEUE_DEPTH_DEF = 64;

   // Depth of the command queue between the front and the back.
   localparam int CMD_QUEUE_DEPTH = 2;

   // Reset value of the per-entry byte overhead register.
   localparam logic [7:0] OVERHEAD_RESET = 8'd64;

   // Action codes as they arrive on the request channel.
   typedef enum logic [2:0] {
      ACT_PUT    = 3'd0,
      ACT_MARKER = 3'd1,
      ACT_GET    = 3'd2,
      ACT_FLUSH  = 3'd3,
      ACT_ABORT  = 3'd4,
      ACT_START  = 3'd5
   } action_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_PUT_OK    = 3'd0,
      ST_REJ_ABORT = 3'd1,
      ST_REJ_FULL  = 3'd2,
      ST_GOT       = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_GET_ABORT = 3'd5,
      ST_DONE      = 3'd6
   } status_type;

   // Operation classes decoded by the front.
   typedef enum logic [2:0] {
      OP_PUT,
      OP_MARKER,
      OP_GET,
      OP_FLUSH,
      OP_ABORT,
      OP_START,
      OP_NONE
   } op_type;

   // States of the back part's sequencer.
   typedef enum logic [1:0] {
      BK_EXEC,
      BK_READ,
      BK_SECOND
   } back_state_type;

   // One stored descriptor with its generation serial.
   typedef struct packed {
      logic [31:0] handle;
      logic [23:0] size;
      logic [31:0] duration;
      logic [7:0]  stream;
      logic [31:0] serial;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // A classified item travelling from the front to the back.
   typedef struct packed {
      op_type      op;
      logic        wait_if_empty;
      logic [31:0] handle;
      logic [23:0] size;
      logic [31:0] duration;
      logic [7:0]  stream;
   } cmd_type;

   // One result item.
   typedef struct packed {
      status_type  status;
      logic [31:0] out_handle;
      logic [23:0] out_size;
      logic [31:0] out_duration;
      logic [7:0]  out_stream;
      logic [31:0] out_serial;
      logic [6:0]  entry_count;
      logic [31:0] byte_total;
      logic [39:0] duration_total;
      logic        is_aborted;
      logic        last_of_run;
   } rsp_type;

endpackage

// ===== sv/stpf_if.sv =====
// Request and result channel interfaces of the serial tagged packet queue.
interface stpf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] pkt_handle;
   logic [23:0] pkt_size;
   logic [31:0] pkt_duration;
   logic [7:0]  stream_id;
   logic        wait_if_empty;

   modport source (
      output valid, action, pkt_handle, pkt_size, pkt_duration, stream_id, wait_if_empty,
      input  ready
   );
   modport sink (
      input  valid, action, pkt_handle, pkt_size, pkt_duration, stream_id, wait_if_empty,
      output ready
   );
endinterface

interface stpf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] out_handle;
   logic [23:0] out_size;
   logic [31:0] out_duration;
   logic [7:0]  out_stream;
   logic [31:0] out_serial;
   logic [6:0]  entry_count;
   logic [31:0] byte_total;
   logic [39:0] duration_total;
   logic        is_aborted;
   logic        last_of_run;

   modport source (
      output valid, status, out_handle, out_size, out_duration, out_stream, out_serial,
             entry_count, byte_total, duration_total, is_aborted, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, status, out_handle, out_size, out_duration, out_stream, out_serial,
             entry_count, byte_total, duration_total, is_aborted, last_of_run,
      output ready
   );
endinterface

// ===== sv/serial_tagged_packet_fifo_unit.sv =====
// Top level of the serial tagged packet queue.
//
// Request items on req_ch carry an action (put, put flush marker, get, flush,
// abort, start) and a packet descriptor. Result items on rsp_ch carry a status,
// the dequeued descriptor with its generation serial, and the queue totals after
// that result; last_of_run marks the final result of an item. An item gives zero,
// one or two results. A waiting get on an empty queue gives none and is answered
// by the next successful put, or failed by an abort.
// csr_we and csr_wdata write the per-entry byte overhead; the user must do so only
// while the block is idle, as the block itself does not enforce it. A request item
// is taken into a two-entry command queue and executed by the back part, which
// registers its results. The back part executes one item per cycle while the
// result register is free; a get that reads the store and an item with two
// results each take an extra state, BK_READ or BK_SECOND, set by the registered
// read port of the descriptor memory and the single result register.
// After reset the queue is empty, the serial is zero, the overhead is 64 and the
// queue is aborted until a start. When the receiver stalls, the result register
// holds and the command queue fills before req_ch.ready falls.
module serial_tagged_packet_fifo_unit #(
   parameter int QUEUE_DEPTH = stpf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   stpf_req_if.sink    req_ch,
   stpf_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic               push_valid;
   stpf_pkg::cmd_type  push_cmd;
   logic               queue_full;
   logic               cmd_valid;
   stpf_pkg::cmd_type  cmd;
   logic               cmd_pop;

   // Accept and classify items.
   stpf_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // Decoupling queue.
   stpf_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop_valid  (cmd_valid),
      .pop_cmd    (cmd),
      .pop        (cmd_pop)
   );

   // Execute commands and produce results.
   stpf_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== sv/stpf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module stpf_ram #(
   parameter int WIDTH = stpf_pkg::ENTRY_W,
   parameter int DEPTH = stpf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/stpf_front.sv =====
// Front part: accepts request items and classifies them into commands.
module stpf_front (
   stpf_req_if.sink           req_ch,
   input  logic               queue_full,
   output logic               push_valid,
   output stpf_pkg::cmd_type  push_cmd
);

   stpf_pkg::op_type op;

   // An item is taken whenever the command queue has room.
   assign req_ch.ready = !queue_full;
   assign push_valid   = req_ch.valid && !queue_full;

   // Decode the action code into an operation class.
   always_comb begin
      case (req_ch.action)
         stpf_pkg::ACT_PUT:    op = stpf_pkg::OP_PUT;
         stpf_pkg::ACT_MARKER: op = stpf_pkg::OP_MARKER;
         stpf_pkg::ACT_GET:    op = stpf_pkg::OP_GET;
         stpf_pkg::ACT_FLUSH:  op = stpf_pkg::OP_FLUSH;
         stpf_pkg::ACT_ABORT:  op = stpf_pkg::OP_ABORT;
         stpf_pkg::ACT_START:  op = stpf_pkg::OP_START;
         default:              op = stpf_pkg::OP_NONE;
      endcase
   end

   // Bundle the classified item.
   always_comb begin
      push_cmd.op            = op;
      push_cmd.wait_if_empty = req_ch.wait_if_empty;
      push_cmd.handle        = req_ch.pkt_handle;
      push_cmd.size          = req_ch.pkt_size;
      push_cmd.duration      = req_ch.pkt_duration;
      push_cmd.stream        = req_ch.stream_id;
   end

endmodule

// ===== sv/stpf_cmd_queue.sv =====
// Short command queue that decouples the front from the back.
module stpf_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  stpf_pkg::cmd_type  push_cmd,
   output logic               full,
   output logic               pop_valid,
   output stpf_pkg::cmd_type  pop_cmd,
   input  logic               pop
);

   localparam int DEPTH = stpf_pkg::CMD_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   stpf_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/stpf_back.sv =====
// Back part: executes commands against the descriptor store and drives results.
module stpf_back #(
   parameter int QUEUE_DEPTH = stpf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  stpf_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata,
   stpf_rsp_if.source         rsp_ch
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   stpf_pkg::back_state_type   state_ff, state_in;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]           occ_ff, occ_in;
   logic [31:0]                bytes_ff, bytes_in;
   logic [39:0]                dur_ff, dur_in;
   logic [31:0]                gen_ff, gen_in;
   logic                       abort_ff, abort_in;
   logic                       pend_ff, pend_in;
   logic [7:0]                 ovh_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   stpf_pkg::rsp_type          rsp_ff, rsp_in;
   stpf_pkg::rsp_type          second_ff, second_in;

   logic                       ram_we;
   logic [PTR_W-1:0]           ram_wa;
   stpf_pkg::entry_type        ram_wd;
   logic                       ram_re;
   logic [stpf_pkg::ENTRY_W-1:0] ram_rd;
   stpf_pkg::entry_type        got;

   assign got = stpf_pkg::entry_type'(ram_rd);

   // Descriptor store.
   stpf_ram #(
      .WIDTH (stpf_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rd)
   );

   // Circular pointer increment.
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Fill in the queue state that a result reports.
   function automatic stpf_pkg::rsp_type with_state(
      input stpf_pkg::rsp_type r,
      input logic [CNT_W-1:0]  occ,
      input logic [31:0]       bytes,
      input logic [39:0]       dur,
      input logic              ab
   );
      stpf_pkg::rsp_type  o;
      logic [CNT_W+6:0]   wide;
      o                = r;
      wide             = (CNT_W + 7)'(occ);
      o.entry_count    = wide[6:0];
      o.byte_total     = bytes;
      o.duration_total = dur;
      o.is_aborted     = ab;
      return o;
   endfunction

   // Command execution and result sequencing.
   always_comb begin
      stpf_pkg::rsp_type   res;
      stpf_pkg::rsp_type   sec;
      stpf_pkg::entry_type ent;
      logic [CNT_W-1:0]    occ_e;
      logic [31:0]         bytes_e;
      logic [39:0]         dur_e;
      logic [31:0]         gen_v;
      logic                abort_v;
      logic                emit_v;
      logic                out_free;

      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      bytes_in     = bytes_ff;
      dur_in       = dur_ff;
      gen_in       = gen_ff;
      abort_in     = abort_ff;
      pend_in      = pend_ff;
      second_in    = second_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ch.ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;

      res          = '0;
      sec          = '0;
      ent          = '0;
      occ_e        = occ_ff;
      bytes_e      = bytes_ff;
      dur_e        = dur_ff;
      gen_v        = gen_ff;
      abort_v      = abort_ff;
      emit_v       = 1'b0;

      ent.handle   = cmd.handle;
      ent.size     = cmd.size;
      ent.duration = cmd.duration;
      ent.stream   = cmd.stream;
      ent.serial   = gen_ff;

      case (state_ff)
         stpf_pkg::BK_EXEC: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               emit_v  = 1'b1;
               case (cmd.op)
                  stpf_pkg::OP_PUT, stpf_pkg::OP_MARKER, stpf_pkg::OP_START: begin
                     if (cmd.op == stpf_pkg::OP_START) begin
                        abort_v = 1'b0;
                     end
                     abort_in = abort_v;
                     if (abort_v) begin
                        res.status = stpf_pkg::ST_REJ_ABORT;
                     end else if (occ_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        res.status = stpf_pkg::ST_REJ_FULL;
                     end else begin
                        // Markers and starts bump the serial before they are stored.
                        if (cmd.op != stpf_pkg::OP_PUT) begin
                           gen_v = gen_ff + 32'd1;
                        end
                        ent.serial = gen_v;
                        ram_we     = 1'b1;
                        tail_in    = advance(tail_ff);
                        occ_e      = occ_ff + 1'b1;
                        bytes_e    = bytes_ff + 32'(cmd.size) + 32'(ovh_ff);
                        dur_e      = dur_ff + 40'(cmd.duration);
                        gen_in     = gen_v;
                        occ_in     = occ_e;
                        bytes_in   = bytes_e;
                        dur_in     = dur_e;
                        res.status = stpf_pkg::ST_PUT_OK;
                        // A held get only exists on an empty queue, so it takes
                        // this very entry and the queue is empty again.
                        if (pend_ff) begin
                           pend_in          = 1'b0;
                           head_in          = advance(head_ff);
                           occ_in           = occ_e - 1'b1;
                           bytes_in         = '0;
                           dur_in           = '0;
                           sec.status       = stpf_pkg::ST_GOT;
                           sec.out_handle   = ent.handle;
                           sec.out_size     = ent.size;
                           sec.out_duration = ent.duration;
                           sec.out_stream   = ent.stream;
                           sec.out_serial   = ent.serial;
                           sec.last_of_run  = 1'b1;
                           second_in        = with_state(sec, occ_e - 1'b1, '0, '0, abort_v);
                           state_in         = stpf_pkg::BK_SECOND;
                        end
                     end
                  end
                  stpf_pkg::OP_GET: begin
                     if (abort_ff) begin
                        res.status = stpf_pkg::ST_GET_ABORT;
                     end else if (occ_ff != '0) begin
                        ram_re   = 1'b1;
                        emit_v   = 1'b0;
                        state_in = stpf_pkg::BK_READ;
                     end else if (cmd.wait_if_empty && !pend_ff) begin
                        pend_in = 1'b1;
                        emit_v  = 1'b0;
                     end else begin
                        res.status = stpf_pkg::ST_EMPTY;
                     end
                  end
                  stpf_pkg::OP_FLUSH: begin
                     head_in    = '0;
                     tail_in    = '0;
                     occ_e      = '0;
                     bytes_e    = '0;
                     dur_e      = '0;
                     occ_in     = '0;
                     bytes_in   = '0;
                     dur_in     = '0;
                     res.status = stpf_pkg::ST_DONE;
                  end
                  stpf_pkg::OP_ABORT: begin
                     abort_v  = 1'b1;
                     abort_in = 1'b1;
                     if (pend_ff) begin
                        pend_in         = 1'b0;
                        res.status      = stpf_pkg::ST_GET_ABORT;
                        sec.status      = stpf_pkg::ST_DONE;
                        sec.last_of_run = 1'b1;
                        second_in       = with_state(sec, occ_ff, bytes_ff, dur_ff, 1'b1);
                        state_in        = stpf_pkg::BK_SECOND;
                     end else begin
                        res.status = stpf_pkg::ST_DONE;
                     end
                  end
                  default: begin
                     res.status = stpf_pkg::ST_DONE;
                  end
               endcase
               if (emit_v) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in             = with_state(res, occ_e, bytes_e, dur_e, abort_v);
                  rsp_in.last_of_run = (state_in == stpf_pkg::BK_EXEC);
               end
            end
         end
         stpf_pkg::BK_READ: begin
            // The head entry is on the read port; dequeue it now.
            if (out_free) begin
               occ_e   = occ_ff - 1'b1;
               head_in = advance(head_ff);
               if (occ_e == '0) begin
                  bytes_e = '0;
                  dur_e   = '0;
               end else begin
                  bytes_e = bytes_ff - 32'(got.size) - 32'(ovh_ff);
                  dur_e   = dur_ff - 40'(got.duration);
               end
               occ_in           = occ_e;
               bytes_in         = bytes_e;
               dur_in           = dur_e;
               res.status       = stpf_pkg::ST_GOT;
               res.out_handle   = got.handle;
               res.out_size     = got.size;
               res.out_duration = got.duration;
               res.out_stream   = got.stream;
               res.out_serial   = got.serial;
               res.last_of_run  = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_in           = with_state(res, occ_e, bytes_e, dur_e, abort_ff);
               state_in         = stpf_pkg::BK_EXEC;
            end
         end
         stpf_pkg::BK_SECOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = second_ff;
               state_in     = stpf_pkg::BK_EXEC;
            end
         end
         default: begin
            state_in = stpf_pkg::BK_EXEC;
         end
      endcase

      ram_wa = tail_ff;
      ram_wd = ent;
   end

   // Control and queue state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stpf_pkg::BK_EXEC;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         bytes_ff     <= '0;
         dur_ff       <= '0;
         gen_ff       <= '0;
         abort_ff     <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         bytes_ff     <= bytes_in;
         dur_ff       <= dur_in;
         gen_ff       <= gen_in;
         abort_ff     <= abort_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Overhead register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovh_ff <= stpf_pkg::OVERHEAD_RESET;
      end else if (csr_we) begin
         ovh_ff <= csr_wdata;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      second_ff <= second_in;
   end

   // Drive the result channel.
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.out_handle     = rsp_ff.out_handle;
   assign rsp_ch.out_size       = rsp_ff.out_size;
   assign rsp_ch.out_duration   = rsp_ff.out_duration;
   assign rsp_ch.out_stream     = rsp_ff.out_stream;
   assign rsp_ch.out_serial     = rsp_ff.out_serial;
   assign rsp_ch.entry_count    = rsp_ff.entry_count;
   assign rsp_ch.byte_total     = rsp_ff.byte_total;
   assign rsp_ch.duration_total = rsp_ff.duration_total;
   assign rsp_ch.is_aborted     = rsp_ff.is_aborted;
   assign rsp_ch.last_of_run    = rsp_ff.last_of_run;

endmodule
